/* src/mt64_pkg.sv */
package mt64_pkg;

    localparam int unsigned WORDS      = 312;
    localparam int unsigned HALF       = WORDS / 2;
    localparam int unsigned AW         = $clog2(WORDS);

    localparam logic [AW-1:0] LAST_ADDR = AW'(WORDS - 1);
    localparam logic [AW-1:0] HALF_ADDR = AW'(HALF);

    localparam logic [63:0] TWIST_MATRIX = 64'hB502_6F5A_A966_19E9;
    localparam logic [63:0] UPPER_MASK   = 64'hFFFF_FFFF_8000_0000;
    localparam logic [63:0] LOWER_MASK   = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] INIT_MULT    = 64'd6364136223846793005;
    localparam logic [63:0] MIX_MULT_A   = 64'd3935559000370003845;
    localparam logic [63:0] MIX_MULT_B   = 64'd2862933555777941757;
    localparam logic [63:0] INIT_WORD    = 64'd19650218;
    localparam logic [63:0] TOP_BIT      = 64'h8000_0000_0000_0000;

    localparam logic [7:0] REG_SEED      = 8'd0;
    localparam logic [7:0] REG_RANGE_CAP = 8'd1;

    localparam logic KIND_DRAW   = 1'b0;
    localparam logic KIND_RESEED = 1'b1;

    localparam logic STATUS_OK         = 1'b0;
    localparam logic STATUS_NOT_SEEDED = 1'b1;

    typedef struct packed {
        logic          en;
        logic [AW-1:0] addr;
        logic [63:0]   data;
    } t_mem_wr;

endpackage

/* src/mt64_random_generator.sv */
// MT19937-64 random source with KISS-driven seeding. The 312 twister words live in one
// synchronous memory with one write port and one read port (the controller issues one read
// or one write a cycle; read data is registered); a shared 64x64 multiplier built from one
// 32x32 unit and a bit-serial modulo unit do the arithmetic. A reseed transfer (tuser = 1)
// gives no result. A draw transfer (tuser = 0) gives one result, reduced by each nonzero
// modulus (range_cap, then the extra range in tdata) in the remainder unit, which makes one
// bit a cycle; the first draw after a reseed and every 312th draw after it first rebuild the
// array word by word through the memory port. A draw before any reseed returns value 0 with
// status 1 at once. Only one item is in flight; a finished result waits in the output
// register while the next item is taken. Write configuration only while idle: index 0 is
// the seed, index 1 is range_cap (reset all ones).
module mt64_random_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,    // [63:0] extra_range
    input  logic        i_s_tuser,    // [0] kind
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,    // [63:0] value
    output logic        o_m_tuser,    // [0] status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    localparam int unsigned AW = mt64_pkg::AW;

    typedef enum logic [22:0] {
        S_IDLE     = 23'h000001,
        S_SEED     = 23'h000002,
        S_FA_MUL   = 23'h000004,
        S_FA_WAIT  = 23'h000008,
        S_B_K1     = 23'h000010,
        S_B_K2     = 23'h000020,
        S_B_MUL    = 23'h000040,
        S_B_WAIT   = 23'h000080,
        S_C_MUL    = 23'h000100,
        S_C_WAIT   = 23'h000200,
        S_FIN      = 23'h000400,
        S_RG_START = 23'h000800,
        S_RG_LD    = 23'h001000,
        S_RG_RN    = 23'h002000,
        S_RG_RF    = 23'h004000,
        S_RG_WR    = 23'h008000,
        S_DR_RD    = 23'h010000,
        S_DR_T     = 23'h020000,
        S_DR_M1    = 23'h040000,
        S_DR_M1W   = 23'h080000,
        S_DR_M2    = 23'h100000,
        S_DR_M2W   = 23'h200000,
        S_OUT      = 23'h400000
    } t_state;

    t_state      r_state;

    // configuration and control state
    logic [63:0] r_seed;
    logic [63:0] r_range_cap;
    logic [AW:0] r_idx;            // holds WORDS when exhausted
    logic        r_seeded;
    logic [31:0] r_kz;
    logic [31:0] r_kw;
    logic [31:0] r_ks;
    logic [31:0] r_kc;

    // working registers
    logic [AW-1:0] r_i;
    logic [AW-1:0] r_j;
    logic [63:0]   r_p;
    logic [63:0]   r_key;
    logic [63:0]   r_cur;
    logic [63:0]   r_nxt;
    logic [63:0]   r_extra;
    logic [63:0]   r_x;
    logic          r_status;
    logic          r_ovalid;
    logic [63:0]   r_odata;
    logic          r_ostatus;

    // memory, multiplier and modulo hookups
    mt64_pkg::t_mem_wr mem_wr;
    logic              mem_rd_en;
    logic [AW-1:0]     mem_rd_addr;
    logic [63:0]       mem_rd_data;
    logic              mul_start;
    logic [63:0]       mul_b;
    logic              mul_done;
    logic [63:0]       mul_prod;
    logic              mod_start;
    logic [63:0]       mod_d;
    logic              mod_done;
    logic [63:0]       mod_rem;

    logic          in_xfer;
    logic          out_free;
    logic [31:0]   seed_fold;
    logic [63:0]   p_mix;
    logic [AW-1:0] i_wrap;
    logic [AW-1:0] next_addr;
    logic [AW-1:0] far_addr;
    logic [63:0]   twist_x;
    logic [63:0]   twist_val;
    logic [63:0]   b_val;
    logic [63:0]   c_val;
    logic [63:0]   fa_val;
    logic [63:0]   t1;
    logic [63:0]   t2;
    logic [63:0]   t3;
    logic [63:0]   tempered;

    // KISS step
    logic [31:0] kz_n;
    logic [31:0] kw_n;
    logic [31:0] kc_n;
    logic [31:0] ks1;
    logic [31:0] ks2;
    logic [31:0] ks_n;
    logic [31:0] kiss_out;

    assign kz_n     = 32'd36969 * {16'd0, r_kz[15:0]} + {16'd0, r_kz[31:16]};
    assign kw_n     = 32'd18000 * {16'd0, r_kw[15:0]} + {16'd0, r_kw[31:16]};
    assign kc_n     = 32'd69069 * r_kc + 32'd1234567;
    assign ks1      = r_ks ^ (r_ks >> 13);
    assign ks2      = ks1 ^ (ks1 << 17);
    assign ks_n     = ks2 ^ (ks2 << 5);
    assign kiss_out = (({kz_n[15:0], 16'd0} + kw_n) ^ kc_n) + ks_n;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_xfer     = i_s_tvalid && o_s_tready;
    assign out_free    = !r_ovalid || i_m_tready;

    assign seed_fold = r_seed[63:32] ^ r_seed[31:0];
    assign p_mix     = r_p ^ (r_p >> 62);
    assign i_wrap    = (r_i == mt64_pkg::LAST_ADDR) ? AW'(1) : r_i + AW'(1);
    assign next_addr = (r_i == mt64_pkg::LAST_ADDR) ? '0 : r_i + AW'(1);
    assign far_addr  = (r_i < mt64_pkg::HALF_ADDR) ? r_i + mt64_pkg::HALF_ADDR
                                                   : r_i - mt64_pkg::HALF_ADDR;

    assign fa_val = mul_prod + {{(64-AW){1'b0}}, r_i};
    assign b_val  = (mem_rd_data ^ mul_prod) + r_key + {{(64-AW){1'b0}}, r_j};
    assign c_val  = (mem_rd_data ^ mul_prod) - {{(64-AW){1'b0}}, r_i};

    // regeneration: far word arrives from memory in the write cycle
    assign twist_x   = (r_cur & mt64_pkg::UPPER_MASK) | (r_nxt & mt64_pkg::LOWER_MASK);
    assign twist_val = mem_rd_data ^ (twist_x >> 1)
                       ^ (twist_x[0] ? mt64_pkg::TWIST_MATRIX : 64'd0);

    // tempering
    assign t1       = mem_rd_data ^ ((mem_rd_data >> 29) & 64'h5555_5555_5555_5555);
    assign t2       = t1 ^ ((t1 << 17) & 64'h71D6_7FFF_EDA6_0000);
    assign t3       = t2 ^ ((t2 << 37) & 64'hFFF7_EEE0_0000_0000);
    assign tempered = t3 ^ (t3 >> 43);

    // memory, multiplier and modulo requests per state
    always_comb begin
        mem_wr      = '0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = r_i;
        mul_start   = 1'b0;
        mul_b       = mt64_pkg::INIT_MULT;
        mod_start   = 1'b0;
        mod_d       = r_range_cap;
        case (r_state)
            S_SEED: begin
                mem_wr = '{en: 1'b1, addr: '0, data: mt64_pkg::INIT_WORD};
            end
            S_FA_MUL: begin
                mul_start = 1'b1;
            end
            S_FA_WAIT: begin
                mem_wr = '{en: mul_done, addr: r_i, data: fa_val};
            end
            S_B_MUL: begin
                mul_start = 1'b1;
                mul_b     = mt64_pkg::MIX_MULT_A;
                mem_rd_en = 1'b1;
            end
            S_B_WAIT: begin
                mem_wr = '{en: mul_done, addr: r_i, data: b_val};
            end
            S_C_MUL: begin
                mul_start = 1'b1;
                mul_b     = mt64_pkg::MIX_MULT_B;
                mem_rd_en = 1'b1;
            end
            S_C_WAIT: begin
                mem_wr = '{en: mul_done, addr: r_i, data: c_val};
            end
            S_FIN: begin
                mem_wr = '{en: 1'b1, addr: '0, data: mt64_pkg::TOP_BIT};
            end
            S_RG_START: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = '0;
            end
            S_RG_RN: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = next_addr;
            end
            S_RG_RF: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = far_addr;
            end
            S_RG_WR: begin
                mem_wr = '{en: 1'b1, addr: r_i, data: twist_val};
            end
            S_DR_RD: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = r_idx[AW-1:0];
            end
            S_DR_M1: begin
                mod_start = (r_range_cap != 64'd0);
            end
            S_DR_M2: begin
                mod_start = (r_extra != 64'd0);
                mod_d     = r_extra;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seed      <= 64'd0;
            r_range_cap <= '1;
            r_idx       <= (AW+1)'(mt64_pkg::WORDS);
            r_seeded    <= 1'b0;
            r_kz        <= 32'd0;
            r_kw        <= 32'd0;
            r_ks        <= 32'd0;
            r_kc        <= 32'd0;
            r_ovalid    <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == mt64_pkg::REG_SEED) begin
                    r_seed <= i_cfg_data;
                end else if (i_cfg_index == mt64_pkg::REG_RANGE_CAP) begin
                    r_range_cap <= i_cfg_data;
                end
            end
            // drop valid after the transfer unless a new result loads this cycle
            if (r_ovalid && i_m_tready && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_extra <= i_s_tdata;
                        if (i_s_tuser == mt64_pkg::KIND_RESEED) begin
                            r_state <= S_SEED;
                        end else if (!r_seeded) begin
                            r_x      <= 64'd0;
                            r_status <= mt64_pkg::STATUS_NOT_SEEDED;
                            r_state  <= S_OUT;
                        end else if (r_idx >= (AW+1)'(mt64_pkg::WORDS)) begin
                            r_state <= S_RG_START;
                        end else begin
                            r_state <= S_DR_RD;
                        end
                    end
                end
                S_SEED: begin
                    r_kz    <= seed_fold ^ 32'd362436069;
                    r_kw    <= seed_fold ^ 32'd521288629;
                    r_ks    <= seed_fold ^ 32'd123456789;
                    r_kc    <= seed_fold ^ 32'd380116160;
                    r_p     <= mt64_pkg::INIT_WORD;
                    r_i     <= AW'(1);
                    r_state <= S_FA_MUL;
                end
                S_FA_MUL: begin
                    r_state <= S_FA_WAIT;
                end
                S_FA_WAIT: begin
                    if (mul_done) begin
                        r_p <= fa_val;
                        if (r_i == mt64_pkg::LAST_ADDR) begin
                            r_i     <= AW'(1);
                            r_j     <= '0;
                            r_p     <= mt64_pkg::INIT_WORD;
                            r_state <= S_B_K1;
                        end else begin
                            r_i     <= r_i + AW'(1);
                            r_state <= S_FA_MUL;
                        end
                    end
                end
                S_B_K1, S_B_K2: begin
                    r_kz <= kz_n;
                    r_kw <= kw_n;
                    r_ks <= ks_n;
                    r_kc <= kc_n;
                    if (r_state == S_B_K1) begin
                        r_key[63:32] <= kiss_out;
                        r_state      <= S_B_K2;
                    end else begin
                        r_key[31:0] <= kiss_out;
                        r_state     <= S_B_MUL;
                    end
                end
                S_B_MUL: begin
                    r_state <= S_B_WAIT;
                end
                S_B_WAIT: begin
                    if (mul_done) begin
                        r_p <= b_val;
                        r_i <= i_wrap;
                        if (r_j == mt64_pkg::LAST_ADDR) begin
                            r_j     <= '0;
                            r_state <= S_C_MUL;
                        end else begin
                            r_j     <= r_j + AW'(1);
                            r_state <= S_B_K1;
                        end
                    end
                end
                S_C_MUL: begin
                    r_state <= S_C_WAIT;
                end
                S_C_WAIT: begin
                    if (mul_done) begin
                        r_p <= c_val;
                        r_i <= i_wrap;
                        if (r_j == mt64_pkg::LAST_ADDR - AW'(1)) begin
                            r_state <= S_FIN;
                        end else begin
                            r_j     <= r_j + AW'(1);
                            r_state <= S_C_MUL;
                        end
                    end
                end
                S_FIN: begin
                    r_idx    <= (AW+1)'(mt64_pkg::WORDS);
                    r_seeded <= 1'b1;
                    r_state  <= S_IDLE;
                end
                S_RG_START: begin
                    r_i     <= '0;
                    r_state <= S_RG_LD;
                end
                S_RG_LD: begin
                    r_cur   <= mem_rd_data;
                    r_state <= S_RG_RN;
                end
                S_RG_RN: begin
                    r_state <= S_RG_RF;
                end
                S_RG_RF: begin
                    r_nxt   <= mem_rd_data;
                    r_state <= S_RG_WR;
                end
                S_RG_WR: begin
                    r_cur <= r_nxt;
                    if (r_i == mt64_pkg::LAST_ADDR) begin
                        r_idx   <= '0;
                        r_state <= S_DR_RD;
                    end else begin
                        r_i     <= r_i + AW'(1);
                        r_state <= S_RG_RN;
                    end
                end
                S_DR_RD: begin
                    r_idx   <= r_idx + (AW+1)'(1);
                    r_state <= S_DR_T;
                end
                S_DR_T: begin
                    r_x      <= tempered;
                    r_status <= mt64_pkg::STATUS_OK;
                    r_state  <= S_DR_M1;
                end
                S_DR_M1: begin
                    r_state <= (r_range_cap != 64'd0) ? S_DR_M1W : S_DR_M2;
                end
                S_DR_M1W: begin
                    if (mod_done) begin
                        r_x     <= mod_rem;
                        r_state <= S_DR_M2;
                    end
                end
                S_DR_M2: begin
                    r_state <= (r_extra != 64'd0) ? S_DR_M2W : S_OUT;
                end
                S_DR_M2W: begin
                    if (mod_done) begin
                        r_x     <= mod_rem;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (out_free) begin
                        r_ovalid  <= 1'b1;
                        r_odata   <= r_x;
                        r_ostatus <= r_status;
                        r_state   <= S_IDLE;
                    end else begin
                        r_ovalid  <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ostatus;

    mt64_store u_store (
        .i_clk     (i_clk),
        .i_wr      (mem_wr),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    mt64_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (p_mix),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    mt64_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_x     (r_x),
        .i_d     (mod_d),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

`ifndef ASSERT_OFF
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == mt64_pkg::STATUS_NOT_SEEDED) |-> o_m_tdata == 64'd0)
        else $error("not-seeded result carries nonzero value");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= (AW+1)'(mt64_pkg::WORDS))
        else $error("read index past end of array");

    a_wr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_wr.en |-> mem_wr.addr <= mt64_pkg::LAST_ADDR)
        else $error("memory write outside array");
`endif

endmodule

/* src/mt64_store.sv */
module mt64_store (
    input  logic                      i_clk,
    input  mt64_pkg::t_mem_wr         i_wr,
    input  logic                      i_rd_en,
    input  logic [mt64_pkg::AW-1:0]   i_rd_addr,
    output logic [63:0]               o_rd_data
);

    logic [63:0] r_mem [mt64_pkg::WORDS];
    logic [63:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/mt64_mul.sv */
module mt64_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_prod
);

    logic        r_busy;
    logic        r_done;
    logic [1:0]  r_cnt;
    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [63:0] r_m;
    logic [63:0] r_acc;
    logic [31:0] opx;
    logic [31:0] opy;

    // low 64 bits: alo*blo + ((alo*bhi + ahi*blo) << 32)
    always_comb begin
        case (r_cnt)
            2'd0:    begin opx = r_a[31:0];  opy = r_b[31:0];  end
            2'd1:    begin opx = r_a[31:0];  opy = r_b[63:32]; end
            default: begin opx = r_a[63:32]; opy = r_b[31:0];  end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 2'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        if (r_busy) begin
            r_m <= {32'd0, opx} * {32'd0, opy};
            case (r_cnt)
                2'd1:    r_acc <= r_m;
                2'd2:    r_acc <= r_acc + {r_m[31:0], 32'd0};
                2'd3:    r_acc <= r_acc + {r_m[31:0], 32'd0};
                default: r_acc <= r_acc;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

/* src/mt64_mod.sv */
module mt64_mod (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_x,
    input  logic [63:0] i_d,
    output logic        o_done,
    output logic [63:0] o_rem
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_x;
    logic [63:0] r_d;
    logic [63:0] r_rem;
    logic [64:0] trial;
    logic [64:0] diff;

    // one quotient bit a cycle, restoring form
    assign trial = {r_rem, r_x[63]};
    assign diff  = trial - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_d   <= i_d;
            r_rem <= 64'd0;
        end else if (r_busy) begin
            r_x   <= {r_x[62:0], 1'b0};
            r_rem <= diff[64] ? trial[63:0] : diff[63:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule
